// ===== rtl/xgc_pkg.sv =====
// Shared types and constants for the pixel composer.
// Holds channel, request-kind and register codes; has no dependencies.
package xgc_pkg;

	localparam int NUM_LANES   = 3;
	localparam int TABLE_DEPTH = 256;

	typedef logic [1:0] chan_t;
	typedef logic [NUM_LANES-1:0][7:0] lane_bytes_t;

	localparam chan_t CH_RED   = 2'd0;
	localparam chan_t CH_GREEN = 2'd1;
	localparam chan_t CH_BLUE  = 2'd2;

	// Lane order follows the output byte order: blue, green, red.
	localparam chan_t [NUM_LANES-1:0] LANE_CH = {CH_RED, CH_GREEN, CH_BLUE};

	localparam logic ACT_COMPOSE     = 1'b0;
	localparam logic ACT_TABLE_WRITE = 1'b1;

	localparam logic CFG_SOURCE_IS_XBGR = 1'b0;
	localparam logic CFG_GAMMA_ENABLE   = 1'b1;

	localparam logic [15:0] ONES16    = 16'hffff;
	localparam logic [31:0] ROUND_HI  = 32'h0000_7fff;
	localparam logic [16:0] DIV_LIMIT = 17'd65535;
	localparam logic [16:0] DIV_TWICE = 17'd131070;
	localparam logic [16:0] ROUND_LO  = 17'h00080;
	localparam logic [16:0] RECIP_257 = 17'd65281;
	localparam logic [7:0]  ALPHA_MAX = 8'hff;
	localparam logic [7:0]  ALPHA_MIN = 8'h00;
	localparam logic [7:0]  FILL_BYTE = 8'hff;

endpackage

// ===== rtl/xgc_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; used for each gamma table bank of the pixel composer.
module xgc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/xrgb_gamma_cursor_pixel_composer.sv =====
// Pixel composer: gamma mapping of the primary pixel and cursor blending.
// A compose request passes through registered stages s1 to s4 before the output.
// One request per cycle when not stalled; all three gamma banks are read per compose.
// A stalled output freezes the whole pipeline, and the input is then not ready.
// Reset clears the valid bits and both configuration registers; the gamma table is
// not cleared and each entry holds no defined value until it is written.
module xrgb_gamma_cursor_pixel_composer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// primary_word, cursor_word, cursor_present, table_channel, table_index,
	// table_value, zero fill
	input  logic [87:0] s_tdata,
	// action
	input  logic [0:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_word
	output logic [31:0] m_tdata,
	output logic        m_tlast
);
	import xgc_pkg::*;

	logic source_is_xbgr_q, gamma_enable_q;
	logic en, acc, compose;

	logic [31:0] prim_in, cur_in;
	logic        present_in;
	chan_t       ch_in;
	logic [7:0]  idx_in, val_in;
	lane_bytes_t raw_in, rdata;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        last_s1, last_s2, last_s3;
	logic        present_s1, present_s2, present_s3;
	logic [31:0] cur_s1, cur_s2, cur_s3;
	lane_bytes_t raw_s1, prim_s2, prim_s3;
	logic [NUM_LANES-1:0][31:0] sum_s2;
	logic [NUM_LANES-1:0][16:0] q_s3;
	logic [31:0] data_s4;
	logic        last_s4;

	lane_bytes_t prim_s1c;
	logic [NUM_LANES-1:0][31:0] sum_s1c;
	logic [NUM_LANES-1:0][16:0] q_s2c;
	lane_bytes_t res_s3c;

	assign prim_in    = s_tdata[31:0];
	assign cur_in     = s_tdata[63:32];
	assign present_in = s_tdata[64];
	assign ch_in      = s_tdata[66:65];
	assign idx_in     = s_tdata[74:67];
	assign val_in     = s_tdata[82:75];

	assign en       = !v_s4 || m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid && en;
	assign compose  = acc && (s_tuser[0] == ACT_COMPOSE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_is_xbgr_q <= 1'b0;
			gamma_enable_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SOURCE_IS_XBGR: source_is_xbgr_q <= cfg_wdata;
				CFG_GAMMA_ENABLE:   gamma_enable_q   <= cfg_wdata;
				default:            ;
			endcase
		end
	end

	always_comb begin
		raw_in[1] = prim_in[15:8];
		if (source_is_xbgr_q) begin
			raw_in[0] = prim_in[23:16];
			raw_in[2] = prim_in[7:0];
		end else begin
			raw_in[0] = prim_in[7:0];
			raw_in[2] = prim_in[23:16];
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_bank
		xgc_ram #(
			.WIDTH(8),
			.DEPTH(TABLE_DEPTH)
		) u_gamma (
			.clk  (clk),
			.we   (acc && (s_tuser[0] == ACT_TABLE_WRITE) && (ch_in == LANE_CH[l])),
			.waddr(idx_in),
			.wdata(val_in),
			.re   (compose),
			.raddr(raw_in[l]),
			.rdata(rdata[l])
		);
	end

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			logic [15:0] c16, p16, na16;
			c16 = {cur_s1[8*l +: 8], cur_s1[8*l +: 8]};
			prim_s1c[l] = gamma_enable_q ? rdata[l] : raw_s1[l];
			p16 = {prim_s1c[l], prim_s1c[l]};
			na16 = ONES16 - {cur_s1[31:24], cur_s1[31:24]};
			sum_s1c[l] = ({c16, 16'h0000} - {16'h0000, c16}) + (p16 * na16);
		end
	end

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			logic [31:0] x;
			logic [16:0] r;
			logic [1:0]  inc;
			x = sum_s2[l] + ROUND_HI;
			r = {1'b0, x[15:0]} + {1'b0, x[31:16]};
			if (r >= DIV_TWICE) begin
				inc = 2'd2;
			end else if (r >= DIV_LIMIT) begin
				inc = 2'd1;
			end else begin
				inc = 2'd0;
			end
			q_s2c[l] = {1'b0, x[31:16]} + {15'd0, inc};
		end
	end

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			logic [16:0] y;
			logic [33:0] prod;
			logic [7:0]  c;
			y = q_s3[l] + ROUND_LO;
			prod = y * RECIP_257;
			c = cur_s3[8*l +: 8];
			if (!present_s3 || cur_s3[31:24] == ALPHA_MIN) begin
				res_s3c[l] = prim_s3[l];
			end else if (cur_s3[31:24] == ALPHA_MAX) begin
				res_s3c[l] = c;
			end else begin
				res_s3c[l] = prod[31:24];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= compose;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1    <= s_tlast;
			present_s1 <= present_in;
			cur_s1     <= cur_in;
			raw_s1     <= raw_in;
			last_s2    <= last_s1;
			present_s2 <= present_s1;
			cur_s2     <= cur_s1;
			prim_s2    <= prim_s1c;
			sum_s2     <= sum_s1c;
			last_s3    <= last_s2;
			present_s3 <= present_s2;
			cur_s3     <= cur_s2;
			prim_s3    <= prim_s2;
			q_s3       <= q_s2c;
			last_s4    <= last_s3;
			data_s4    <= {FILL_BYTE, res_s3c[2], res_s3c[1], res_s3c[0]};
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = data_s4;
	assign m_tlast  = last_s4;

`ifndef SYNTHESIS
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !m_tready) |-> !s_tready)
		else $error("input accepted while output stalled");

	a_table_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == ACT_TABLE_WRITE) |=> !v_s1)
		else $error("table write request entered the pixel pipeline");

	a_compose_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == ACT_COMPOSE) |=> v_s1)
		else $error("compose request lost at pipeline entry");

	a_stall_holds_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && v_s2) |=> $stable(sum_s2))
		else $error("blend sum changed during a stall");
`endif

endmodule
